// ----- hw/rtl/dhi_pkg.sv -----
// ---------------------------------------------------------------------------
// Debye histogram package
// Shared constants, types and helper functions of the distance histogram.
// ---------------------------------------------------------------------------
package dhi_pkg;

    localparam int NUM_BINS = 1024;
    localparam int BIN_AW   = $clog2(NUM_BINS);
    localparam int BIN_CW   = BIN_AW + 1;

    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [31:0] BIN_WIDTH_RST  = 32'd655;
    localparam logic [10:0] BIN_COUNT_RST  = 11'd1024;
    localparam logic [63:0] INT64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN      = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef enum logic {
        CFG_BIN_WIDTH = 1'b0,
        CFG_BIN_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_ADD_DIV, ST_ADD_RD, ST_ADD_WR,
        ST_Q_P, ST_Q_PW, ST_Q_RD, ST_Q_CHK, ST_X_HI, ST_X_CMB,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
        ST_ZZ, ST_ZW, ST_H, ST_HR, ST_FIN, ST_FINR, ST_DIVW,
        ST_T_HI, ST_T_LO, ST_T_SUM, ST_ACC, ST_NEXT, ST_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    // Horner coefficients in Q30: sine series when big is set, sinc series otherwise.
    function automatic logic [30:0] coef(input logic big, input logic [2:0] idx);
        logic [30:0] c;
        c = '0;
        if (big) begin
            case (idx)
                3'd0:    c = 31'd1686629713;
                3'd1:    c = 31'd693598668;
                3'd2:    c = 31'd85569306;
                3'd3:    c = 31'd5026995;
                3'd4:    c = 31'd172272;
                3'd5:    c = 31'd3864;
                3'd6:    c = 31'd61;
                default: c = '0;
            endcase
        end else begin
            case (idx)
                3'd0:    c = 31'd178956971;
                3'd1:    c = 31'd8947849;
                3'd2:    c = 31'd213044;
                3'd3:    c = 31'd2959;
                3'd4:    c = 31'd27;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            s = a[63] ? INT64_MIN : INT64_MAX;
        end
        return s;
    endfunction

endpackage

// ----- hw/rtl/dhi_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module dhi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/dhi_mul.sv -----
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ---------------------------------------------------------------------------
module dhi_mul
    import dhi_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/dhi_div.sv -----
// ---------------------------------------------------------------------------
// Iterative divider
// Unsigned 64 by 64 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module dhi_div
    import dhi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [64:0] w_rem_sh;
    logic        w_ge;
    logic [64:0] w_rem_n;

    assign w_rem_sh = {r_rem, r_quo[63]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};
    assign w_rem_n  = w_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_n[63:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hw/rtl/debye_pair_histogram_intensity.sv -----
// ---------------------------------------------------------------------------
// Debye pair histogram intensity
// Weighted pair-distance histogram with a sin(x)/x weighted intensity query.
// ---------------------------------------------------------------------------
// An add-pair word waits on the iterative bin divider.
// A clear writes the bins, one bin written per cycle.
// A query walks the bins in turn: an empty bin is skipped, q = 0 skips the
// series, and the short series skips the phase path and the final division.
// One word is in flight at a time; the result register lets the next word in.
// After reset the histogram is cleared before any word is taken.
module debye_pair_histogram_intensity
    import dhi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pair_distance, pair_weight, q_value
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // intensity, status, zero padding
);

    t_state r_state, n_state;

    logic [31:0]       r_bw;
    logic [10:0]       r_bc;
    logic              r_clr_item;
    logic [31:0]       r_wt;
    logic [31:0]       r_q;
    logic [63:0]       r_int;
    logic              r_stat;
    logic [BIN_AW-1:0] r_addr;
    logic [63:0]       r_p;
    logic [63:0]       r_part;
    logic [62:0]       r_x2;
    logic [127:0]      r_ph;
    logic [1:0]        r_quad;
    logic [30:0]       r_z;
    logic [30:0]       r_w;
    logic [30:0]       r_hp;
    logic [2:0]        r_ci;
    logic              r_big;
    logic [30:0]       r_f;
    logic              r_fneg;
    logic [63:0]       r_val;
    logic [63:0]       r_term;
    logic              r_out_valid;
    logic [71:0]       r_out_data;

    logic              w_accept;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic              ram_we;
    logic [63:0]       ram_wdata;
    logic [63:0]       ram_rdata;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [BIN_CW-1:0] w_n;
    logic [BIN_CW-1:0] w_nm1;
    logic [10:0]       w_k;
    logic [75:0]       w_x2;
    logic [127:0]      w_ph_full;
    logic [31:0]       w_ph;
    logic [30:0]       w_t;
    logic [30:0]       w_coef;
    logic [30:0]       w_hp_n;
    logic [30:0]       w_s;
    logic [30:0]       w_fs;
    logic [63:0]       w_m;
    logic              w_tneg;
    logic [63:0]       w_r0;
    logic [63:0]       w_lim;
    logic [63:0]       w_r;
    logic [63:0]       w_wt64;
    logic              w_last;

    dhi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    dhi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dhi_ram #(
        .WIDTH (64),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Bins in use: zero acts as one, anything past the array acts as the array.
    always_comb begin
        if (r_bc == '0) begin
            w_n = BIN_CW'(1);
        end else if (r_bc > BIN_CW'(NUM_BINS)) begin
            w_n = BIN_CW'(NUM_BINS);
        end else begin
            w_n = r_bc;
        end
    end

    assign w_nm1     = w_n - BIN_CW'(1);
    assign w_last    = r_addr == w_nm1[BIN_AW-1:0];
    assign w_k       = {r_addr, 1'b1};
    assign w_x2      = {prod[43:0], 32'b0} + {32'b0, r_part[43:0]};
    assign w_ph_full = r_ph + {prod, 64'b0};
    assign w_ph      = w_ph_full[96:65];
    assign w_t       = prod[60:30];
    assign w_coef    = coef(r_big, r_ci);
    assign w_hp_n    = (w_coef > w_t) ? (w_coef - w_t) : '0;
    assign w_s       = (w_t > ONE_Q30) ? ONE_Q30 : w_t;
    assign w_fs      = (w_t < ONE_Q30) ? (ONE_Q30 - w_t) : '0;
    assign w_m       = r_val[63] ? (~r_val + 64'd1) : r_val;
    assign w_tneg    = r_val[63] ^ r_fneg;
    assign w_wt64    = {{32{r_wt[31]}}, r_wt};

    // Term magnitude is (hi << 18) + (lo >> 14), clamped to the signed limit.
    assign w_r0  = {1'b0, r_part[44:0], 18'b0} + {14'b0, prod[63:14]};
    assign w_lim = w_tneg ? INT64_MIN : INT64_MAX;
    always_comb begin
        if (|r_part[63:45]) begin
            w_r = w_lim;
        end else if (w_r0 > w_lim) begin
            w_r = w_lim;
        end else begin
            w_r = w_r0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_addr == BIN_AW'(NUM_BINS - 1)) begin
                    n_state = r_clr_item ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (t_op'(s_axis_tuser))
                        OP_ADD:   n_state = ST_ADD_DIV;
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_QUERY: n_state = ST_Q_P;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD_DIV: begin
                if (div_rsp.done) begin
                    n_state = (div_rsp.quotient >= 64'(w_n)) ? ST_DONE : ST_ADD_RD;
                end
            end
            ST_ADD_RD: n_state = ST_ADD_WR;
            ST_ADD_WR: n_state = ST_DONE;
            ST_Q_P:    n_state = ST_Q_PW;
            ST_Q_PW:   n_state = ST_Q_RD;
            ST_Q_RD:   n_state = ST_Q_CHK;
            ST_Q_CHK: begin
                if (ram_rdata == '0) begin
                    n_state = ST_NEXT;
                end else if (r_q == '0) begin
                    n_state = ST_T_HI;
                end else begin
                    n_state = ST_X_HI;
                end
            end
            ST_X_HI: n_state = ST_X_CMB;
            ST_X_CMB: begin
                if (|w_x2[75:63]) begin
                    n_state = ST_NEXT;
                end else if (w_x2[62:33] == '0) begin
                    n_state = ST_ZZ;
                end else begin
                    n_state = ST_P0;
                end
            end
            ST_P0: n_state = ST_P1;
            ST_P1: n_state = ST_P2;
            ST_P2: n_state = ST_P3;
            ST_P3: n_state = ST_P4;
            ST_P4: n_state = ST_ZZ;
            ST_ZZ: n_state = ST_ZW;
            ST_ZW: n_state = ST_H;
            ST_H:  n_state = ST_HR;
            ST_HR: n_state = (r_ci == '0) ? ST_FIN : ST_H;
            ST_FIN: n_state = ST_FINR;
            ST_FINR: n_state = r_big ? ST_DIVW : ST_T_HI;
            ST_DIVW: begin
                if (div_rsp.done) begin
                    n_state = ST_T_HI;
                end
            end
            ST_T_HI:  n_state = ST_T_LO;
            ST_T_LO:  n_state = ST_T_SUM;
            ST_T_SUM: n_state = ST_ACC;
            ST_ACC:   n_state = ST_NEXT;
            ST_NEXT:  n_state = w_last ? ST_DONE : ST_Q_RD;
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controls: multiplier operands, bin memory writes, divider starts and input ready.
    always_comb begin
        mul_a            = '0;
        mul_b            = '0;
        ram_we           = 1'b0;
        ram_wdata        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        s_axis_tready    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_IDLE: begin
                s_axis_tready    = 1'b1;
                div_req.start    = w_accept && (t_op'(s_axis_tuser) == OP_ADD);
                div_req.dividend = {32'b0, s_axis_tdata[31:0]};
                div_req.divisor  = {32'b0, (r_bw == '0) ? 32'd1 : r_bw};
            end
            ST_ADD_WR: begin
                ram_we    = 1'b1;
                ram_wdata = sat_add(ram_rdata, w_wt64);
            end
            ST_Q_P: begin
                mul_a = r_q;
                mul_b = r_bw;
            end
            ST_Q_CHK: begin
                mul_a = r_p[31:0];
                mul_b = 32'(w_k);
            end
            ST_X_HI: begin
                mul_a = r_p[63:32];
                mul_b = 32'(w_k);
            end
            ST_P0: begin
                mul_a = r_x2[31:0];
                mul_b = INV_TWO_PI_Q64[31:0];
            end
            ST_P1: begin
                mul_a = r_x2[31:0];
                mul_b = INV_TWO_PI_Q64[63:32];
            end
            ST_P2: begin
                mul_a = {1'b0, r_x2[62:32]};
                mul_b = INV_TWO_PI_Q64[31:0];
            end
            ST_P3: begin
                mul_a = {1'b0, r_x2[62:32]};
                mul_b = INV_TWO_PI_Q64[63:32];
            end
            ST_ZZ: begin
                mul_a = {1'b0, r_z};
                mul_b = {1'b0, r_z};
            end
            ST_H: begin
                mul_a = {1'b0, r_w};
                mul_b = {1'b0, r_hp};
            end
            ST_FIN: begin
                mul_a = {1'b0, r_big ? r_z : r_w};
                mul_b = {1'b0, r_hp};
            end
            ST_FINR: begin
                div_req.start    = r_big;
                div_req.dividend = {w_s, 33'b0};
                div_req.divisor  = {1'b0, r_x2};
            end
            ST_T_HI: begin
                mul_a = w_m[63:32];
                mul_b = {1'b0, r_f};
            end
            ST_T_LO: begin
                mul_a = w_m[31:0];
                mul_b = {1'b0, r_f};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_addr     <= '0;
            r_clr_item <= 1'b0;
            r_bw       <= BIN_WIDTH_RST;
            r_bc       <= BIN_COUNT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BIN_WIDTH: r_bw <= i_cfg_data;
                    CFG_BIN_COUNT: r_bc <= i_cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + BIN_AW'(1);
                    if (r_addr == BIN_AW'(NUM_BINS - 1)) begin
                        r_clr_item <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    r_addr     <= '0;
                    r_clr_item <= w_accept && (t_op'(s_axis_tuser) == OP_CLEAR);
                end
                ST_ADD_DIV: begin
                    r_addr <= div_rsp.quotient[BIN_AW-1:0];
                end
                ST_Q_PW: begin
                    r_addr <= '0;
                end
                ST_NEXT: begin
                    r_addr <= r_addr + BIN_AW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Item datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_wt   <= s_axis_tdata[63:32];
                    r_q    <= s_axis_tdata[95:64];
                    r_int  <= '0;
                    r_stat <= 1'b0;
                end
            end
            ST_ADD_DIV: begin
                if (div_rsp.done && (div_rsp.quotient >= 64'(w_n))) begin
                    r_stat <= 1'b1;
                end
            end
            ST_Q_PW: begin
                r_p <= prod;
            end
            ST_Q_CHK: begin
                r_val  <= ram_rdata;
                r_f    <= ONE_Q30;
                r_fneg <= 1'b0;
            end
            ST_X_HI: begin
                r_part <= prod;
            end
            ST_X_CMB: begin
                r_x2  <= w_x2[62:0];
                r_z   <= {1'b0, w_x2[32:3]};
                r_big <= |w_x2[62:33];
            end
            ST_P1: begin
                r_ph <= {64'b0, prod};
            end
            ST_P2, ST_P3: begin
                r_ph <= r_ph + {32'b0, prod, 32'b0};
            end
            ST_P4: begin
                r_quad <= w_ph[31:30];
                r_z    <= w_ph[30] ? (ONE_Q30 - {1'b0, w_ph[29:0]}) : {1'b0, w_ph[29:0]};
            end
            ST_ZW: begin
                r_w  <= w_t;
                r_hp <= r_big ? coef(1'b1, 3'd6) : coef(1'b0, 3'd4);
                r_ci <= r_big ? 3'd5 : 3'd3;
            end
            ST_HR: begin
                r_hp <= w_hp_n;
                r_ci <= r_ci - 3'd1;
            end
            ST_FINR: begin
                r_f    <= w_fs;
                r_fneg <= r_big && r_quad[1];
            end
            ST_DIVW: begin
                if (div_rsp.done) begin
                    r_f <= div_rsp.quotient[30:0];
                    if (div_rsp.quotient == '0) begin
                        r_fneg <= 1'b0;
                    end
                end
            end
            ST_T_LO: begin
                r_part <= prod;
            end
            ST_T_SUM: begin
                r_term <= w_tneg ? (~w_r + 64'd1) : w_r;
            end
            ST_ACC: begin
                r_int <= sat_add(r_int, r_term);
            end
            default: begin
            end
        endcase
    end

    // Result register: a finished word waits here while the next one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {7'b0, r_stat, r_int};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
